[rtl/core/lobu_pkg.sv]
// package: types, constants and codes for the limit order book update block
package lobu_pkg;

  // sizes of the order table and of each side's level list
  localparam int unsigned ORDER_SLOTS = 1024;
  localparam int unsigned LEVELS      = 64;

  localparam int unsigned OS_AW  = $clog2(ORDER_SLOTS);
  localparam int unsigned LVL_AW = $clog2(LEVELS);
  localparam int unsigned CNT_W  = $clog2(LEVELS + 1);
  localparam int unsigned LQ_W   = 42;

  typedef logic [OS_AW-1:0]  ord_addr_t;
  typedef logic [LVL_AW-1:0] lvl_idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [6:0]        lvl_cnt_out_t;

  // message kinds
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_DIFFERS = 3'd3,
    ST_SHORT   = 3'd4,
    ST_MISSING = 3'd5,
    ST_FULL    = 3'd6
  } status_e;

  // quote state codes
  typedef enum logic [1:0] {
    QUOTE_NORMAL  = 2'd0,
    QUOTE_ONESIDE = 2'd1,
    QUOTE_CROSSED = 2'd2
  } quote_e;

  // order table live codes
  typedef enum logic [1:0] {
    LIVE_NONE = 2'd0,
    LIVE_BUY  = 2'd1,
    LIVE_SELL = 2'd2
  } live_e;

  // control sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ORD_RD,
    S_ORD_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SH_UP_RD,
    S_SH_UP_WR,
    S_INS,
    S_SH_DN_RD,
    S_SH_DN_WR,
    S_COMMIT,
    S_FINISH
  } state_e;

  // request word
  typedef struct packed {
    logic [1:0]  kind;
    logic        side;
    logic [9:0]  order_id;
    logic [31:0] qty;
    logic [31:0] price;
  } req_t;

  // result word
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] best_bid;
    logic [31:0] best_ask;
    logic [1:0]  quote_state;
    logic [31:0] mid_price;
    logic [6:0]  bid_levels;
    logic [6:0]  ask_levels;
  } res_t;

  // order table entry
  typedef struct packed {
    logic [1:0]  live;
    logic [31:0] qty;
    logic [31:0] price;
  } ord_t;

  // price level entry
  typedef struct packed {
    logic [31:0]     price;
    logic [LQ_W-1:0] qty;
  } lvl_t;

endpackage

[rtl/core/limit_order_book_update.sv]
// top level: order table and sorted price level lists with quote output
//
// channel  | handshake             | word
// ---------+-----------------------+--------------------------
// request  | start, busy           | req_i  (kind..price)
// result   | done_o strobe, 1 cyc  | res_o  (status..levels)
//
// a word of kind three goes straight to the result, and a reject at order lookup
// skips the level scan; otherwise the block scans the levels ahead of the
// position and then moves levels one at a time through the single read port
// of the level ram. the block takes no new word until the result is out.
// after reset a clearing pass over every order slot empties the order table,
// busy stays high during it. the result cannot be stalled.
module limit_order_book_update (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  lobu_pkg::req_t  req_i,
  output logic            done_o,
  output lobu_pkg::res_t  res_o
);

  lobu_pkg::state_e state_q, state_d;
  lobu_pkg::req_t   req_q;
  lobu_pkg::ord_t   ord_q, ord_d;
  lobu_pkg::status_e st_q, st_d;
  lobu_pkg::cnt_t   idx_q, idx_d;
  lobu_pkg::cnt_t   sh_q, sh_d;
  lobu_pkg::cnt_t   bid_cnt_q, ask_cnt_q, n_cur, n_m1;
  lobu_pkg::ord_addr_t clr_q;
  logic             found_q, found_d;
  logic [lobu_pkg::LQ_W-1:0] lq_q, lq_d, add_q, sub_q, new_q;
  logic [31:0]      best_bid_q, best_ask_q;
  lobu_pkg::res_t   res_q, res_d;
  logic             done_q, done_d;
  logic             cnt_inc, cnt_dec;
  logic             accept;

  // order ram ports
  logic                ord_we;
  lobu_pkg::ord_addr_t ord_waddr, ord_raddr;
  lobu_pkg::ord_t      ord_wdata, ord_rdata;

  // level ram ports, side in the top address bit
  logic                     lvl_we;
  lobu_pkg::cnt_t           lvl_widx, lvl_ridx;
  logic [lobu_pkg::LVL_AW:0] lvl_waddr, lvl_raddr;
  lobu_pkg::lvl_t           lvl_wdata, lvl_rdata;

  logic is_add, is_cancel, ahead, short_lvl;
  logic [32:0] mid_sum;
  logic [31:0] bb, ba;

  assign accept  = start && (state_q == lobu_pkg::S_IDLE);
  assign busy    = (state_q != lobu_pkg::S_IDLE);
  assign done_o  = done_q;
  assign res_o   = res_q;

  assign is_add    = (req_q.kind == lobu_pkg::KIND_ADD);
  assign is_cancel = (req_q.kind == lobu_pkg::KIND_CANCEL);
  assign n_cur     = req_q.side ? ask_cnt_q : bid_cnt_q;
  assign n_m1      = n_cur - lobu_pkg::CNT_W'(1);

  // level quantity arithmetic, wraps modulo 2^42
  assign add_q     = lq_q + lobu_pkg::LQ_W'(req_q.qty);
  assign sub_q     = lq_q - lobu_pkg::LQ_W'(ord_q.qty);
  assign new_q     = is_cancel ? sub_q : sub_q + lobu_pkg::LQ_W'(req_q.qty);
  assign short_lvl = lq_q < lobu_pkg::LQ_W'(ord_q.qty);

  // scan compare: level lies ahead of the request price
  assign ahead = req_q.side ? (lvl_rdata.price < req_q.price)
                            : (lvl_rdata.price > req_q.price);

  assign lvl_waddr = {req_q.side, lvl_widx[lobu_pkg::LVL_AW-1:0]};
  assign lvl_raddr = {req_q.side, lvl_ridx[lobu_pkg::LVL_AW-1:0]};
  assign ord_raddr = lobu_pkg::ord_addr_t'(req_q.order_id);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lobu_pkg::S_CLEAR: begin
        if (clr_q == lobu_pkg::ord_addr_t'(lobu_pkg::ORDER_SLOTS - 1)) begin
          state_d = lobu_pkg::S_IDLE;
        end
      end
      lobu_pkg::S_IDLE: begin
        if (accept) begin
          if (req_i.kind == lobu_pkg::KIND_NONE ||
              32'(req_i.order_id) >= 32'(lobu_pkg::ORDER_SLOTS)) begin
            state_d = lobu_pkg::S_FINISH;
          end else begin
            state_d = lobu_pkg::S_ORD_RD;
          end
        end
      end
      lobu_pkg::S_ORD_RD: state_d = lobu_pkg::S_ORD_CHK;
      lobu_pkg::S_ORD_CHK: begin
        if (is_add) begin
          state_d = (ord_rdata.live != lobu_pkg::LIVE_NONE) ? lobu_pkg::S_FINISH
                                                            : lobu_pkg::S_SCAN_RD;
        end else if (ord_rdata.live != (req_q.side ? lobu_pkg::LIVE_SELL
                                                   : lobu_pkg::LIVE_BUY) ||
                     ord_rdata.price != req_q.price ||
                     (is_cancel && ord_rdata.qty != req_q.qty)) begin
          state_d = lobu_pkg::S_FINISH;
        end else begin
          state_d = lobu_pkg::S_SCAN_RD;
        end
      end
      lobu_pkg::S_SCAN_RD: begin
        state_d = (idx_q >= n_cur) ? lobu_pkg::S_DECIDE : lobu_pkg::S_SCAN_CHK;
      end
      lobu_pkg::S_SCAN_CHK: begin
        state_d = ahead ? lobu_pkg::S_SCAN_RD : lobu_pkg::S_DECIDE;
      end
      lobu_pkg::S_DECIDE: begin
        if (is_add) begin
          if (found_q || idx_q == n_cur) begin
            state_d = (!found_q && n_cur >= lobu_pkg::CNT_W'(lobu_pkg::LEVELS))
                      ? lobu_pkg::S_FINISH : lobu_pkg::S_COMMIT;
          end else if (n_cur >= lobu_pkg::CNT_W'(lobu_pkg::LEVELS)) begin
            state_d = lobu_pkg::S_FINISH;
          end else begin
            state_d = lobu_pkg::S_SH_UP_RD;
          end
        end else if (!found_q || short_lvl) begin
          state_d = lobu_pkg::S_FINISH;
        end else if (new_q == '0 && idx_q != n_m1) begin
          state_d = lobu_pkg::S_SH_DN_RD;
        end else begin
          state_d = lobu_pkg::S_COMMIT;
        end
      end
      lobu_pkg::S_SH_UP_RD: state_d = lobu_pkg::S_SH_UP_WR;
      lobu_pkg::S_SH_UP_WR: begin
        state_d = (sh_q - lobu_pkg::CNT_W'(1) == idx_q) ? lobu_pkg::S_INS
                                                       : lobu_pkg::S_SH_UP_RD;
      end
      lobu_pkg::S_INS:      state_d = lobu_pkg::S_COMMIT;
      lobu_pkg::S_SH_DN_RD: state_d = lobu_pkg::S_SH_DN_WR;
      lobu_pkg::S_SH_DN_WR: begin
        state_d = (sh_q + lobu_pkg::CNT_W'(2) == n_cur) ? lobu_pkg::S_COMMIT
                                                       : lobu_pkg::S_SH_DN_RD;
      end
      lobu_pkg::S_COMMIT: state_d = lobu_pkg::S_FINISH;
      lobu_pkg::S_FINISH: state_d = lobu_pkg::S_IDLE;
      default:            state_d = lobu_pkg::S_IDLE;
    endcase
  end

  // quote from the current book
  always_comb begin
    bb      = (bid_cnt_q != '0) ? best_bid_q : 32'd0;
    ba      = (ask_cnt_q != '0) ? best_ask_q : 32'd0;
    mid_sum = {1'b0, bb} + {1'b0, ba};
    res_d             = res_q;
    res_d.status      = st_q;
    res_d.best_bid    = bb;
    res_d.best_ask    = ba;
    res_d.bid_levels  = lobu_pkg::lvl_cnt_out_t'(bid_cnt_q);
    res_d.ask_levels  = lobu_pkg::lvl_cnt_out_t'(ask_cnt_q);
    res_d.mid_price   = 32'd0;
    if (bid_cnt_q == '0 || ask_cnt_q == '0) begin
      res_d.quote_state = lobu_pkg::QUOTE_ONESIDE;
    end else if (bb >= ba) begin
      res_d.quote_state = lobu_pkg::QUOTE_CROSSED;
    end else begin
      res_d.quote_state = lobu_pkg::QUOTE_NORMAL;
      res_d.mid_price   = mid_sum[32:1];
    end
  end

  // outputs of the sequencer
  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    sh_d      = sh_q;
    found_d   = found_q;
    lq_d      = lq_q;
    ord_d     = ord_q;
    done_d    = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    ord_we    = 1'b0;
    ord_waddr = ord_raddr;
    ord_wdata = '0;
    lvl_we    = 1'b0;
    lvl_widx  = idx_q;
    lvl_ridx  = idx_q;
    lvl_wdata = {req_q.price, lobu_pkg::LQ_W'(req_q.qty)};
    case (state_q)
      lobu_pkg::S_CLEAR: begin
        ord_we    = 1'b1;
        ord_waddr = clr_q;
      end
      lobu_pkg::S_IDLE: begin
        if (accept) begin
          idx_d = '0;
          st_d  = (req_i.kind != lobu_pkg::KIND_NONE &&
                   32'(req_i.order_id) >= 32'(lobu_pkg::ORDER_SLOTS))
                  ? lobu_pkg::ST_UNKNOWN : lobu_pkg::ST_OK;
        end
      end
      lobu_pkg::S_ORD_CHK: begin
        ord_d = ord_rdata;
        if (is_add) begin
          if (ord_rdata.live != lobu_pkg::LIVE_NONE) begin
            st_d = lobu_pkg::ST_DUP;
          end
        end else if (ord_rdata.live != (req_q.side ? lobu_pkg::LIVE_SELL
                                                   : lobu_pkg::LIVE_BUY)) begin
          st_d = lobu_pkg::ST_UNKNOWN;
        end else if (ord_rdata.price != req_q.price ||
                     (is_cancel && ord_rdata.qty != req_q.qty)) begin
          st_d = lobu_pkg::ST_DIFFERS;
        end
      end
      lobu_pkg::S_SCAN_RD: begin
        lvl_ridx = idx_q;
        found_d  = 1'b0;
      end
      lobu_pkg::S_SCAN_CHK: begin
        lq_d = lvl_rdata.qty;
        if (ahead) begin
          idx_d = idx_q + lobu_pkg::CNT_W'(1);
        end else begin
          found_d = (lvl_rdata.price == req_q.price);
        end
      end
      lobu_pkg::S_DECIDE: begin
        sh_d = is_add ? n_cur : idx_q;
        if (is_add) begin
          if (found_q) begin
            lvl_we    = 1'b1;
            lvl_wdata = {req_q.price, add_q};
          end else if (n_cur >= lobu_pkg::CNT_W'(lobu_pkg::LEVELS)) begin
            st_d = lobu_pkg::ST_FULL;
          end else if (idx_q == n_cur) begin
            lvl_we  = 1'b1;
            cnt_inc = 1'b1;
          end
        end else if (!found_q) begin
          st_d = lobu_pkg::ST_MISSING;
        end else if (short_lvl) begin
          st_d = lobu_pkg::ST_SHORT;
        end else if (new_q == '0) begin
          if (idx_q == n_m1) begin
            cnt_dec = 1'b1;
          end
        end else begin
          lvl_we    = 1'b1;
          lvl_wdata = {req_q.price, new_q};
        end
      end
      lobu_pkg::S_SH_UP_RD: begin
        lvl_ridx = sh_q - lobu_pkg::CNT_W'(1);
      end
      lobu_pkg::S_SH_UP_WR: begin
        lvl_we    = 1'b1;
        lvl_widx  = sh_q;
        lvl_wdata = lvl_rdata;
        sh_d      = sh_q - lobu_pkg::CNT_W'(1);
      end
      lobu_pkg::S_INS: begin
        lvl_we  = 1'b1;
        cnt_inc = 1'b1;
      end
      lobu_pkg::S_SH_DN_RD: begin
        lvl_ridx = sh_q + lobu_pkg::CNT_W'(1);
      end
      lobu_pkg::S_SH_DN_WR: begin
        lvl_we    = 1'b1;
        lvl_widx  = sh_q;
        lvl_wdata = lvl_rdata;
        sh_d      = sh_q + lobu_pkg::CNT_W'(1);
        if (sh_q + lobu_pkg::CNT_W'(2) == n_cur) begin
          cnt_dec = 1'b1;
        end
      end
      lobu_pkg::S_COMMIT: begin
        ord_we = 1'b1;
        if (!is_cancel) begin
          ord_wdata.live  = req_q.side ? lobu_pkg::LIVE_SELL : lobu_pkg::LIVE_BUY;
          ord_wdata.qty   = req_q.qty;
          ord_wdata.price = req_q.price;
        end
      end
      lobu_pkg::S_FINISH: begin
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lobu_pkg::S_CLEAR;
      clr_q     <= '0;
      bid_cnt_q <= '0;
      ask_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (state_q == lobu_pkg::S_CLEAR) begin
        clr_q <= clr_q + lobu_pkg::OS_AW'(1);
      end
      if (cnt_inc) begin
        if (req_q.side) ask_cnt_q <= ask_cnt_q + lobu_pkg::CNT_W'(1);
        else            bid_cnt_q <= bid_cnt_q + lobu_pkg::CNT_W'(1);
      end else if (cnt_dec) begin
        if (req_q.side) ask_cnt_q <= ask_cnt_q - lobu_pkg::CNT_W'(1);
        else            bid_cnt_q <= bid_cnt_q - lobu_pkg::CNT_W'(1);
      end
    end
  end

  // payload registers, best prices track level zero of each side
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    st_q    <= st_d;
    idx_q   <= idx_d;
    sh_q    <= sh_d;
    found_q <= found_d;
    lq_q    <= lq_d;
    ord_q   <= ord_d;
    if (state_q == lobu_pkg::S_FINISH) begin
      res_q <= res_d;
    end
    if (lvl_we && lvl_widx == '0) begin
      if (req_q.side) best_ask_q <= lvl_wdata.price;
      else            best_bid_q <= lvl_wdata.price;
    end
  end

  // order table
  lobu_ram #(
    .Width($bits(lobu_pkg::ord_t)),
    .Depth(lobu_pkg::ORDER_SLOTS)
  ) u_ord_ram (
    .clk_i  (clk_i),
    .we_i   (ord_we),
    .waddr_i(ord_waddr),
    .wdata_i(ord_wdata),
    .raddr_i(ord_raddr),
    .rdata_o(ord_rdata)
  );

  // level lists of both sides
  lobu_ram #(
    .Width($bits(lobu_pkg::lvl_t)),
    .Depth(2 * lobu_pkg::LEVELS)
  ) u_lvl_ram (
    .clk_i  (clk_i),
    .we_i   (lvl_we),
    .waddr_i(lvl_waddr),
    .wdata_i(lvl_wdata),
    .raddr_i(lvl_raddr),
    .rdata_o(lvl_rdata)
  );

endmodule

[rtl/core/lobu_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module lobu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lobu_checker.sv]
// checker: port-level properties of the order book block, bound to the top
module lobu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input lobu_pkg::res_t res_o
);

  // an accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // a result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  // a result only appears when the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  // mid quote is zero unless the quote is normal
  a_mid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.quote_state != lobu_pkg::QUOTE_NORMAL) |-> res_o.mid_price == 32'd0)
    else $error("mid quote set on abnormal quote");

  // level counts stay within the list size
  a_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(res_o.bid_levels) <= 32'(lobu_pkg::LEVELS) &&
                32'(res_o.ask_levels) <= 32'(lobu_pkg::LEVELS)))
    else $error("level count beyond list size");

endmodule

bind limit_order_book_update lobu_checker u_lobu_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .res_o (res_o)
);
